/* rtl/lrue_pkg.sv */
// shared constants and types for the lru block eviction selector
package lrue_pkg;

    localparam int DEF_MAX_ENTRIES = 256;
    localparam int DEF_MAX_SEQS    = 64;
    localparam int DEF_MAX_EVICT   = 64;
    localparam int DEF_TIME_BITS   = 48;

    localparam int SEQ_ID_W   = 6;
    localparam int BLK_IDX_W  = 8;
    localparam int LEN_W      = 9;
    localparam int TS_W       = 48;
    localparam int EVICT_W    = 7;
    localparam int TAG_W      = SEQ_ID_W + BLK_IDX_W;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 16;

    localparam logic [LEN_W-1:0] MIN_BLOCKS_RST = 9'd1;

    // control from the sequencer to the owner table
    typedef struct packed {
        logic len_we;
        logic pick_we;
        logic rd_en;
    } own_ctl_t;

endpackage

/* rtl/lrue_owner_table.sv */
// per-owner length and pick count memories
module lrue_owner_table #(
    parameter int MAX_SEQS = lrue_pkg::DEF_MAX_SEQS,
    parameter int SEQ_W    = 6,
    parameter int PK_W     = 7
) (
    input  logic                     clk,
    input  lrue_pkg::own_ctl_t       ctl,
    input  logic [SEQ_W-1:0]         wr_addr,
    input  logic [lrue_pkg::LEN_W-1:0] len_wdata,
    input  logic [PK_W-1:0]          pick_wdata,
    input  logic [SEQ_W-1:0]         rd_addr,
    output logic [lrue_pkg::LEN_W-1:0] rd_len,
    output logic [PK_W-1:0]          rd_picked
);
    import lrue_pkg::*;

    logic [LEN_W-1:0] len_mem [MAX_SEQS];
    logic [PK_W-1:0]  pick_mem [MAX_SEQS];

    always_ff @(posedge clk)
    begin
        if (ctl.len_we)
        begin
            len_mem[wr_addr] <= len_wdata;
        end
        if (ctl.rd_en)
        begin
            rd_len <= len_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.pick_we)
        begin
            pick_mem[wr_addr] <= pick_wdata;
        end
        if (ctl.rd_en)
        begin
            rd_picked <= pick_mem[rd_addr];
        end
    end

endmodule

/* rtl/lru_block_eviction_select.sv */
// top level of the lru block eviction selector
// Loads page-table entries one per cycle on the slave stream; an entry is
// stored when its block is present, unshared, its owner length exceeds
// min_blocks, its owner id is below MAX_SEQS and the store has room. The
// item with tlast starts selection: first a sweep zeroes the per-owner
// pick counters, then each victim candidate is found by one full scan of
// the entry memory (one memory read port), followed by owner table lookup
// (S_OWN) and check (S_CHECK). Candidates come in order of increasing
// (timestamp, load order), so no visited marks are kept: each scan looks
// for the smallest key above the last one visited. The slave side is held
// off until the request's final result has been loaded into the output
// register. Results stream on the master side, tlast on the final one; a
// request with no victim gives one result with the empty flag set.
// min_blocks is written through min_blocks_we / min_blocks_wdata; the user
// must write it only while the block is idle; the block does not enforce it.
module lru_block_eviction_select #(
    parameter int MAX_ENTRIES = lrue_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_SEQS    = lrue_pkg::DEF_MAX_SEQS,
    parameter int MAX_EVICT   = lrue_pkg::DEF_MAX_EVICT,
    parameter int TIME_BITS   = lrue_pkg::DEF_TIME_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // seq_id[5:0], block_index[13:6], block_present[14], shared[15],
    // seq_length[24:16], timestamp[72:25], evict_count[79:73]
    input  logic [lrue_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // out_seq_id[5:0], out_block_index[13:6], empty_res[14], zero[15]
    output logic [lrue_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              min_blocks_we,
    input  logic [lrue_pkg::LEN_W-1:0]        min_blocks_wdata
);
    import lrue_pkg::*;

    localparam int EA_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int EC_W  = $clog2(MAX_ENTRIES + 1);
    localparam int SEQ_W = (MAX_SEQS > 1) ? $clog2(MAX_SEQS) : 1;
    localparam int PK_W  = $clog2(MAX_EVICT + 1);
    localparam int CMP_W = LEN_W + 2;

    typedef enum logic [2:0] {
        S_LOAD, S_CLEAR, S_SCAN, S_OWN, S_CHECK, S_FIN
    } state_t;

    // input field split
    logic [SEQ_ID_W-1:0]  in_seq;
    logic [BLK_IDX_W-1:0] in_idx;
    logic                 in_present;
    logic                 in_shared;
    logic [LEN_W-1:0]     in_len;
    logic [TS_W-1:0]      in_ts;
    logic [EVICT_W-1:0]   in_evict;

    assign in_seq     = s_tdata[5:0];
    assign in_idx     = s_tdata[13:6];
    assign in_present = s_tdata[14];
    assign in_shared  = s_tdata[15];
    assign in_len     = s_tdata[24:16];
    assign in_ts      = s_tdata[72:25];
    assign in_evict   = s_tdata[79:73];

    state_t               state_reg;
    logic [LEN_W-1:0]     min_blocks_reg;
    logic [EC_W-1:0]      total_reg;
    logic [EC_W-1:0]      cnt_reg;
    logic                 rd_vld_reg;
    logic [EA_W-1:0]      rd_idx_reg;
    logic [SEQ_W-1:0]     clr_reg;
    logic [PK_W-1:0]      want_reg;
    logic [PK_W-1:0]      picked_reg;
    // smallest key above the last visited one, found by the running scan
    logic                 found_reg;
    logic [TIME_BITS-1:0] best_time_reg;
    logic [EA_W-1:0]      best_idx_reg;
    logic [TAG_W-1:0]     best_tag_reg;
    // key of the last visited entry
    logic                 have_last_reg;
    logic [TIME_BITS-1:0] last_time_reg;
    logic [EA_W-1:0]      last_idx_reg;
    // victim held back until it is known whether it is the final one
    logic                 pend_reg;
    logic [TAG_W-1:0]     pend_tag_reg;
    // output register
    logic                 m_tvalid_reg;
    logic                 m_tlast_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // entry memory: timestamp and tag side by side
    logic [TIME_BITS-1:0] time_mem [MAX_ENTRIES];
    logic [TAG_W-1:0]     tag_mem [MAX_ENTRIES];
    logic [TIME_BITS-1:0] rd_time_reg;
    logic [TAG_W-1:0]     rd_tag_reg;

    logic                 in_fire;
    logic                 keep;
    logic                 rd_issue;
    logic                 out_free;
    logic                 out_load;
    logic                 above_last;
    logic                 below_best;
    logic                 owner_ok;
    logic [SEQ_ID_W-1:0]  best_seq;

    own_ctl_t             own_ctl;
    logic [SEQ_W-1:0]     own_wr_addr;
    logic [PK_W-1:0]      own_pick_wdata;
    logic [LEN_W-1:0]     own_rd_len;
    logic [PK_W-1:0]      own_rd_picked;

    assign s_tready = (state_reg == S_LOAD);
    assign in_fire  = s_tvalid && s_tready;
    assign keep     = in_fire && in_present && !in_shared && (in_len > min_blocks_reg)
                      && (32'(in_seq) < MAX_SEQS) && (32'(total_reg) < MAX_ENTRIES);
    assign rd_issue = (state_reg == S_SCAN) && (cnt_reg < total_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign best_seq = best_tag_reg[TAG_W-1:BLK_IDX_W];

    // output register takes a new result: earlier victim or the final one
    assign out_load = ((state_reg == S_CHECK) && owner_ok && pend_reg && out_free)
                      || ((state_reg == S_FIN) && out_free);

    // key order is (timestamp, load position), strictly increasing over visits
    assign above_last = !have_last_reg || (rd_time_reg > last_time_reg)
                        || ((rd_time_reg == last_time_reg) && (rd_idx_reg > last_idx_reg));
    assign below_best = !found_reg || (rd_time_reg < best_time_reg);

    // owner keeps at least min_blocks after losing this one and earlier picks
    assign owner_ok = CMP_W'(own_rd_len)
                      >= (CMP_W'(min_blocks_reg) + CMP_W'(1) + CMP_W'(own_rd_picked));

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            time_mem[total_reg[EA_W-1:0]] <= TIME_BITS'(in_ts);
            tag_mem[total_reg[EA_W-1:0]]  <= {in_seq, in_idx};
        end
        if (rd_issue)
        begin
            rd_time_reg <= time_mem[cnt_reg[EA_W-1:0]];
            rd_tag_reg  <= tag_mem[cnt_reg[EA_W-1:0]];
        end
    end

    // owner table port use: length on load, clear sweep, pick count on check
    always_comb
    begin
        own_ctl.len_we  = keep;
        own_ctl.pick_we = (state_reg == S_CLEAR)
                          || ((state_reg == S_CHECK) && owner_ok && (!pend_reg || out_free));
        own_ctl.rd_en   = (state_reg == S_OWN);
        own_pick_wdata  = '0;
        own_wr_addr     = SEQ_W'(in_seq);
        if (state_reg == S_CLEAR)
        begin
            own_wr_addr = clr_reg;
        end
        else if (state_reg == S_CHECK)
        begin
            own_wr_addr    = SEQ_W'(best_seq);
            own_pick_wdata = own_rd_picked + PK_W'(1);
        end
    end

    lrue_owner_table #(
        .MAX_SEQS (MAX_SEQS),
        .SEQ_W    (SEQ_W),
        .PK_W     (PK_W)
    ) u_owner (
        .clk        (clk),
        .ctl        (own_ctl),
        .wr_addr    (own_wr_addr),
        .len_wdata  (in_len),
        .pick_wdata (own_pick_wdata),
        .rd_addr    (SEQ_W'(best_seq)),
        .rd_len     (own_rd_len),
        .rd_picked  (own_rd_picked)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            min_blocks_reg <= MIN_BLOCKS_RST;
            total_reg      <= '0;
            cnt_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            rd_idx_reg     <= '0;
            clr_reg        <= '0;
            want_reg       <= '0;
            picked_reg     <= '0;
            found_reg      <= 1'b0;
            best_time_reg  <= '0;
            best_idx_reg   <= '0;
            best_tag_reg   <= '0;
            have_last_reg  <= 1'b0;
            last_time_reg  <= '0;
            last_idx_reg   <= '0;
            pend_reg       <= 1'b0;
            pend_tag_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tlast_reg    <= 1'b0;
            m_tdata_reg    <= '0;
        end
        else
        begin
            if (min_blocks_we)
            begin
                min_blocks_reg <= min_blocks_wdata;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (keep)
                    begin
                        total_reg <= total_reg + EC_W'(1);
                    end
                    if (in_fire && s_tlast)
                    begin
                        if (32'(in_evict) > MAX_EVICT)
                        begin
                            want_reg <= PK_W'(MAX_EVICT);
                        end
                        else
                        begin
                            want_reg <= PK_W'(in_evict);
                        end
                        picked_reg    <= '0;
                        clr_reg       <= '0;
                        have_last_reg <= 1'b0;
                        state_reg     <= S_CLEAR;
                    end
                end
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + SEQ_W'(1);
                    if (32'(clr_reg) == MAX_SEQS - 1)
                    begin
                        cnt_reg    <= '0;
                        rd_vld_reg <= 1'b0;
                        found_reg  <= 1'b0;
                        if (want_reg == '0)
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    rd_vld_reg <= rd_issue;
                    rd_idx_reg <= cnt_reg[EA_W-1:0];
                    if (rd_issue)
                    begin
                        cnt_reg <= cnt_reg + EC_W'(1);
                    end
                    if (rd_vld_reg && above_last && below_best)
                    begin
                        found_reg     <= 1'b1;
                        best_time_reg <= rd_time_reg;
                        best_idx_reg  <= rd_idx_reg;
                        best_tag_reg  <= rd_tag_reg;
                    end
                    if (!rd_issue && !rd_vld_reg)
                    begin
                        if (found_reg)
                        begin
                            state_reg <= S_OWN;
                        end
                        else
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_OWN:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    // the counter write lands before the next owner read
                    if (!owner_ok || !pend_reg || out_free)
                    begin
                        have_last_reg <= 1'b1;
                        last_time_reg <= best_time_reg;
                        last_idx_reg  <= best_idx_reg;
                        found_reg     <= 1'b0;
                        cnt_reg       <= '0;
                        rd_vld_reg    <= 1'b0;
                        if (owner_ok)
                        begin
                            if (pend_reg)
                            begin
                                m_tlast_reg  <= 1'b0;
                                m_tdata_reg  <= {2'b00, pend_tag_reg[BLK_IDX_W-1:0],
                                                 pend_tag_reg[TAG_W-1:BLK_IDX_W]};
                            end
                            pend_reg     <= 1'b1;
                            pend_tag_reg <= best_tag_reg;
                            picked_reg   <= picked_reg + PK_W'(1);
                        end
                        if (owner_ok && (picked_reg + PK_W'(1) == want_reg))
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        m_tlast_reg  <= 1'b1;
                        if (pend_reg)
                        begin
                            m_tdata_reg <= {2'b00, pend_tag_reg[BLK_IDX_W-1:0],
                                            pend_tag_reg[TAG_W-1:BLK_IDX_W]};
                        end
                        else
                        begin
                            m_tdata_reg <= {1'b0, 1'b1, {TAG_W{1'b0}}};
                        end
                        pend_reg  <= 1'b0;
                        total_reg <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_pick_le_want: assert property (@(posedge clk) disable iff (!rst_n)
        picked_reg <= want_reg)
        else $error("more victims than requested");

    a_no_pend_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> !pend_reg)
        else $error("victim left behind after request end");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= MAX_ENTRIES)
        else $error("entry count beyond store depth");

    a_key_rises: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) && have_last_reg |->
            (best_time_reg > last_time_reg)
            || ((best_time_reg == last_time_reg) && (best_idx_reg > last_idx_reg)))
        else $error("visit order not increasing");
`endif

endmodule
